[rtl/ptdt_pkg.sv]
// Package for the periodic task dispatch timer.
// Holds the item type carried along the cell chain and the opcode and mask constants.
// No dependencies.
package ptdt_pkg;

    localparam int MASK_BITS = 12;
    localparam int TIME_W    = 32;
    localparam int PERIOD_W  = 16;
    localparam int INDEX_W   = 4;

    typedef enum logic
    {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } opcode_t;

    typedef struct packed
    {
        opcode_t                opcode;
        logic [TIME_W-1:0]      now_time;
        logic [INDEX_W-1:0]     channel_index;
        logic [PERIOD_W-1:0]    period_value;
        logic                   channel_enable;
        logic [MASK_BITS-1:0]   fire_mask;
        logic [MASK_BITS-1:0]   realign_mask;
    } item_t;

endpackage

[rtl/ptdt_cell.sv]
// One channel cell of the dispatch timer chain: period, enable and last-fire time.
// Updates its channel as an item enters, then hands the item on with its mask bits.
// Depends on ptdt_pkg.
module ptdt_cell #(
    parameter int CH = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            up_valid,
    input  ptdt_pkg::item_t up_item,
    output logic            up_ready,
    output logic            dn_valid,
    output ptdt_pkg::item_t dn_item,
    input  logic            dn_ready
);

    logic                            valid_reg;
    logic                            valid_next;
    ptdt_pkg::item_t                 item_reg;
    ptdt_pkg::item_t                 item_next;
    logic [ptdt_pkg::TIME_W-1:0]     last_reg;
    logic [ptdt_pkg::TIME_W-1:0]     last_next;
    logic [ptdt_pkg::PERIOD_W-1:0]   period_reg;
    logic [ptdt_pkg::PERIOD_W-1:0]   period_next;
    logic                            enable_reg;
    logic                            enable_next;
    logic                            take;
    logic                            is_tick;
    logic                            hit;
    logic                            snap;
    logic [ptdt_pkg::TIME_W-1:0]     elapsed;

    assign up_ready = !valid_reg || dn_ready;
    assign take     = up_valid && up_ready;
    assign is_tick  = (up_item.opcode == ptdt_pkg::OP_TICK);
    assign elapsed  = up_item.now_time - last_reg;
    assign hit      = is_tick
                      && (elapsed >= {{(ptdt_pkg::TIME_W-ptdt_pkg::PERIOD_W){1'b0}}, period_reg});
    assign snap     = hit
                      && (elapsed > {{(ptdt_pkg::TIME_W-ptdt_pkg::PERIOD_W-1){1'b0}},
                                     period_reg, 1'b0});

    always_comb
    begin
        valid_next  = valid_reg;
        last_next   = last_reg;
        period_next = period_reg;
        enable_next = enable_reg;
        if (take)
        begin
            valid_next = 1'b1;
            if (!is_tick && (up_item.channel_index == ptdt_pkg::INDEX_W'(CH)))
            begin
                period_next = up_item.period_value;
                enable_next = up_item.channel_enable;
            end
            if (snap)
            begin
                last_next = up_item.now_time;
            end
            else if (hit)
            begin
                last_next = last_reg
                            + {{(ptdt_pkg::TIME_W-ptdt_pkg::PERIOD_W){1'b0}}, period_reg};
            end
        end
        else if (dn_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        item_next              = up_item;
        item_next.fire_mask    = up_item.fire_mask
                                 | (ptdt_pkg::MASK_BITS'(hit && enable_reg) << CH);
        item_next.realign_mask = up_item.realign_mask
                                 | (ptdt_pkg::MASK_BITS'(snap) << CH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            last_reg   <= '0;
            period_reg <= '0;
            enable_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            last_reg   <= last_next;
            period_reg <= period_next;
            enable_reg <= enable_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign dn_valid = valid_reg;
    assign dn_item  = item_reg;

endmodule

[rtl/periodic_task_dispatch_timer.sv]
// Top level of the periodic task dispatch timer: a chain of channel cells.
// Depends on ptdt_pkg and ptdt_cell.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------------
//  in      | in_valid / in_stall  | opcode, now_time, channel_index, period_value,
//          |                      | channel_enable
//  out     | out_valid / out_stall| fire_mask, realign_mask
//
// One transfer in per cycle while in_stall is low; each item passes in turn through
// the register of every channel cell, and its result is presented from the last one.
// Reset clears all periods, enables and last-fire times, and empties the chain.
// A stall on the output holds the last cell; earlier cells keep filling any empty
// slots, and in_stall rises only once every cell holds an item.
module periodic_task_dispatch_timer #(
    parameter int NUM_CHANNELS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [31:0] now_time,
    input  logic [3:0]  channel_index,
    input  logic [15:0] period_value,
    input  logic        channel_enable,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] fire_mask,
    output logic [11:0] realign_mask
);

    logic            link_valid [0:NUM_CHANNELS];
    logic            link_ready [0:NUM_CHANNELS];
    ptdt_pkg::item_t link_item  [0:NUM_CHANNELS];
    ptdt_pkg::item_t in_item;

    always_comb
    begin
        in_item                = '0;
        in_item.opcode         = ptdt_pkg::opcode_t'(opcode);
        in_item.now_time       = now_time;
        in_item.channel_index  = channel_index;
        in_item.period_value   = period_value;
        in_item.channel_enable = channel_enable;
    end

    assign link_item[0]             = in_item;
    assign link_valid[0]            = in_valid;
    assign in_stall                 = !link_ready[0];
    assign link_ready[NUM_CHANNELS] = !out_stall;

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_cell
        ptdt_cell #(
            .CH(c)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (link_valid[c]),
            .up_item  (link_item[c]),
            .up_ready (link_ready[c]),
            .dn_valid (link_valid[c+1]),
            .dn_item  (link_item[c+1]),
            .dn_ready (link_ready[c+1])
        );
    end

    assign out_valid    = link_valid[NUM_CHANNELS];
    assign fire_mask    = link_item[NUM_CHANNELS].fire_mask;
    assign realign_mask = link_item[NUM_CHANNELS].realign_mask;

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while output register empty");

    a_free_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("chain refused a transfer with the output free");

    a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(fire_mask)
                                      && $stable(realign_mask)))
        else $error("stalled result changed or was lost");

endmodule
